// ===== rtl/ffa_pkg.sv =====
// Shared types and constants for the first-fit free list allocator.
// Used by ffa_alu, ffa_list_mem and first_fit_free_list_allocator.
package ffa_pkg;

	localparam int FREE_ENTRIES = 16;
	localparam int OFFSET_BITS  = 32;
	localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

	typedef logic [OFFSET_BITS-1:0] off_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	// request action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_LIST  = 3'd0;
	localparam logic [2:0] ST_BUMP  = 3'd1;
	localparam logic [2:0] ST_FREED = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_OVF   = 3'd4;

	typedef struct packed {
		logic        action;
		logic [31:0] region_offset;
		logic [31:0] region_size;
	} req_t;

	typedef struct packed {
		logic [31:0] granted_offset;
		logic [2:0]  status;
		logic [4:0]  entries_in_list;
	} rsp_t;

	typedef struct packed {
		off_t start;
		off_t length;
	} entry_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		off_t value;
		logic carry;   // carry out on add, borrow on subtract
		logic zero;
	} alu_res_t;

endpackage

// ===== rtl/ffa_alu.sv =====
// Shared add/subtract unit for the allocator sequencer.
// Depends on ffa_pkg for operand and result types.
module ffa_alu (
	input  ffa_pkg::alu_op_t  op,
	input  ffa_pkg::off_t     a,
	input  ffa_pkg::off_t     b,
	output ffa_pkg::alu_res_t res
);
	import ffa_pkg::*;

	logic [OFFSET_BITS:0] wide;

	always_comb begin
		if (op == ALU_SUB) begin
			wide = {1'b0, a} - {1'b0, b};
		end else begin
			wide = {1'b0, a} + {1'b0, b};
		end
		res.value = wide[OFFSET_BITS-1:0];
		res.carry = wide[OFFSET_BITS];
		res.zero  = (wide[OFFSET_BITS-1:0] == '0);
	end

endmodule

// ===== rtl/ffa_list_mem.sv =====
// Free list storage: one write port, one read port with registered data.
// Depends on ffa_pkg for the entry and index types.
module ffa_list_mem (
	input  logic            clk,
	input  logic            wr_en,
	input  ffa_pkg::idx_t   wr_addr,
	input  ffa_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  ffa_pkg::idx_t   rd_addr,
	output ffa_pkg::entry_t rd_data_q
);
	import ffa_pkg::*;

	entry_t mem [FREE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/first_fit_free_list_allocator.sv =====
// Top level of the first-fit free list allocator: sequencer, bump pointer,
// output register. Depends on ffa_pkg, ffa_alu and ffa_list_mem.
//
// Usage: one request per input transfer (in_valid/in_stall/in_data), one
// result per request on the output channel (out_valid/out_stall/out_data).
// Requests are taken one at a time; in_stall is high while a request is worked
// on, so the next one enters the cycle after the previous result is registered.
// Steps from input transfer to out_valid, with the output free:
//   free:               appended in S_IDLE unless zero-size or full, then S_RESP
//   allocate from list: S_RD reads and S_CMP compares each entry in turn up to
//                       the first fit; a split then writes the rest back in
//                       S_SPLIT, an exact fit moves the later entries down
//                       through S_SH_RD/S_SH_WR, then S_RESP
//   allocate from bump: every entry is read and compared, then S_BUMP, S_RESP
// The pace is set by the free list memory (one read per entry, registered data)
// and the single shared add/subtract unit for the size compare, split and bump.
// A finished result waits in the output register while out_stall is high;
// the next request is accepted meanwhile and its result holds in the
// sequencer until the register frees.
// Reset clears the list count and the bump pointer; list contents are not
// cleared, as only entries below the count are ever read.
module first_fit_free_list_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ffa_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output ffa_pkg::rsp_t out_data
);
	import ffa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_SPLIT,
		S_SH_RD,
		S_SH_WR,
		S_BUMP,
		S_RESP
	} state_t;

	localparam cnt_t CNT_FULL = CNT_W'(FREE_ENTRIES);

	state_t     state_q;
	cnt_t       cnt_q;
	cnt_t       idx_q;
	off_t       bump_q;
	off_t       size_q;
	off_t       grant_q;
	off_t       diff_q;
	logic [2:0] st_q;

	logic        mem_wr;
	idx_t        mem_wr_addr;
	entry_t      mem_wr_data;
	logic        mem_rd;
	idx_t        mem_rd_addr;
	entry_t      mem_rd_data;
	alu_op_t     alu_op;
	off_t        alu_a;
	off_t        alu_b;
	alu_res_t    alu_res;
	logic        free_ok;
	logic [CNT_W:0] idx_p1;
	logic [CNT_W:0] idx_p2;

	assign in_stall = (state_q != S_IDLE);

	assign free_ok = (state_q == S_IDLE) && in_valid && (in_data.action == ACT_FREE) &&
		(off_t'(in_data.region_size) != '0) && (cnt_q != CNT_FULL);

	assign idx_p1 = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign idx_p2 = {1'b0, idx_q} + (CNT_W+1)'(2);

	ffa_list_mem u_mem (
		.clk       (clk),
		.wr_en     (mem_wr),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_en     (mem_rd),
		.rd_addr   (mem_rd_addr),
		.rd_data_q (mem_rd_data)
	);

	ffa_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// memory and shared unit steering
	always_comb begin
		mem_wr      = 1'b0;
		mem_wr_addr = idx_q[IDX_W-1:0];
		mem_wr_data = mem_rd_data;
		mem_rd      = 1'b0;
		mem_rd_addr = idx_q[IDX_W-1:0];
		alu_op      = ALU_ADD;
		alu_a       = bump_q;
		alu_b       = size_q;
		unique case (state_q)
			S_IDLE: begin
				mem_wr      = free_ok;
				mem_wr_addr = cnt_q[IDX_W-1:0];
				mem_wr_data = '{start: off_t'(in_data.region_offset),
					length: off_t'(in_data.region_size)};
			end
			S_RD: begin
				mem_rd = (idx_q != cnt_q);
			end
			S_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = mem_rd_data.length;
			end
			S_SPLIT: begin
				alu_a       = mem_rd_data.start;
				mem_wr      = 1'b1;
				mem_wr_data = '{start: alu_res.value, length: diff_q};
			end
			S_SH_RD: begin
				mem_rd      = 1'b1;
				mem_rd_addr = idx_p1[IDX_W-1:0];
			end
			S_SH_WR: begin
				mem_wr = 1'b1;
			end
			S_BUMP: begin
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			bump_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_RESP) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						size_q  <= off_t'(in_data.region_size);
						idx_q   <= '0;
						grant_q <= '0;
						if (in_data.action == ACT_ALLOC) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_RESP;
							if (off_t'(in_data.region_size) == '0) begin
								st_q <= ST_FREED;
							end else if (cnt_q == CNT_FULL) begin
								st_q <= ST_FULL;
							end else begin
								st_q  <= ST_FREED;
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end
					end
				end
				S_RD: begin
					// end of list: fall back to the bump pointer
					state_q <= (idx_q == cnt_q) ? S_BUMP : S_CMP;
				end
				S_CMP: begin
					if (alu_res.carry) begin
						idx_q   <= idx_p1[CNT_W-1:0];
						state_q <= S_RD;
					end else begin
						grant_q <= mem_rd_data.start;
						st_q    <= ST_LIST;
						diff_q  <= alu_res.value;
						if (!alu_res.zero) begin
							state_q <= S_SPLIT;
						end else if (idx_p1 < {1'b0, cnt_q}) begin
							state_q <= S_SH_RD;
						end else begin
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= S_RESP;
						end
					end
				end
				S_SPLIT: begin
					state_q <= S_RESP;
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					// advance the compaction pointer
					idx_q <= idx_p1[CNT_W-1:0];
					if (idx_p2 < {1'b0, cnt_q}) begin
						state_q <= S_SH_RD;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_BUMP: begin
					if (alu_res.carry) begin
						st_q <= ST_OVF;
					end else begin
						st_q    <= ST_BUMP;
						grant_q <= bump_q;
						bump_q  <= alu_res.value;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register frees
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_data  <= '{granted_offset: 32'(grant_q), status: st_q,
							entries_in_list: 5'(cnt_q)};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("free list count above capacity");

	a_bump_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> bump_q >= $past(bump_q))
		else $error("bump pointer moved backward");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_FULL) |-> out_data.entries_in_list == 5'(CNT_FULL))
		else $error("list full reported with free slots");

	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr |-> (state_q == S_IDLE || state_q == S_SPLIT || state_q == S_SH_WR))
		else $error("free list written outside an update step");

	a_shift_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_RD) |-> idx_p1 < {1'b0, cnt_q})
		else $error("compaction read beyond the list");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for first_fit_free_list_allocator: directed and random
// allocate/free traffic, checked against a cycle-free model of the free list.
// Depends on ffa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module testbench;
	import ffa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 40;

	class alloc_scoreboard;
		off_t            region_start [FREE_ENTRIES];
		off_t            region_len   [FREE_ENTRIES];
		int              list_len;
		longint unsigned bump_ptr;
		rsp_t            expected_rsp [$];
		int              mismatches;
		int              requests;
		int              status_hits [5];

		function new();
			list_len = 0;
			bump_ptr = 0;
			mismatches = 0;
			requests = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// Advance the free list and bump pointer for one request.
		function rsp_t apply_request(req_t r);
			rsp_t            res;
			off_t            size;
			int              hit;
			longint unsigned top;
			size = r.region_size[OFFSET_BITS-1:0];
			top = (64'd1 << OFFSET_BITS) - 1;
			res = '0;
			if (r.action == ACT_ALLOC) begin
				hit = -1;
				for (int i = 0; i < list_len; i++)
					if (hit < 0 && region_len[i] >= size) hit = i;
				if (hit >= 0) begin
					res.granted_offset = region_start[hit];
					res.status = ST_LIST;
					if (region_len[hit] > size) begin
						region_start[hit] = region_start[hit] + size;
						region_len[hit] = region_len[hit] - size;
					end else begin
						// exact fit: close the gap
						for (int j = hit; j + 1 < list_len; j++) begin
							region_start[j] = region_start[j+1];
							region_len[j] = region_len[j+1];
						end
						list_len--;
					end
				end else if (bump_ptr + size > top) begin
					res.status = ST_OVF;
				end else begin
					res.granted_offset = bump_ptr[31:0];
					res.status = ST_BUMP;
					bump_ptr = bump_ptr + size;
				end
			end else begin
				if (size == 0) begin
					res.status = ST_FREED;
				end else if (list_len >= FREE_ENTRIES) begin
					res.status = ST_FULL;
				end else begin
					region_start[list_len] = r.region_offset[OFFSET_BITS-1:0];
					region_len[list_len] = size;
					list_len++;
					res.status = ST_FREED;
				end
			end
			res.entries_in_list = list_len[4:0];
			return res;
		endfunction

		function void note_request(req_t r);
			rsp_t res;
			res = apply_request(r);
			expected_rsp = {expected_rsp, res};
			status_hits[res.status]++;
			requests++;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				report("unexpected result", got.granted_offset, 32'h0);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.granted_offset !== want.granted_offset)
				report("granted_offset", got.granted_offset, want.granted_offset);
			if (got.status !== want.status)
				report("status", 32'(got.status), 32'(want.status));
			if (got.entries_in_list !== want.entries_in_list)
				report("entries_in_list", 32'(got.entries_in_list), 32'(want.entries_in_list));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	alloc_scoreboard sb;
	bit idling_on;
	bit hold_request;
	int cycles;

	first_fit_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("first_fit_free_list_allocator regression: fail");
			$finish;
		end
	end

	// Result side: check each transfer, stall in bursts or for one long hold.
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) sb.check_response(out_data);
			if (hold_request) begin
				stall_left = LONG_HOLD;
				hold_request = 0;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 6);
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0) stall_left--;
		end
	end

	function automatic req_t mk_req(logic act, logic [31:0] offs, logic [31:0] size);
		req_t r;
		r.action = act;
		r.region_offset = offs;
		r.region_size = size;
		return r;
	endfunction

	task automatic send_req(req_t r);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Pick a free or an allocate; allocates mostly hit the live list: exact fits and
	// splits of current entries, small bump grants, now and then zero or huge sizes.
	task automatic pick_random_req(output req_t r);
		int          free_pct;
		int          roll;
		int          k;
		logic [31:0] len;
		logic [31:0] size;
		free_pct = (sb.list_len >= 14) ? 30 : (sb.list_len <= 2) ? 70 : 50;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < free_pct) begin
			if (roll < 5) size = 32'h0;
			else if (roll < 25) size = $urandom;
			else size = $urandom_range(1, 65536);
			r = mk_req(ACT_FREE, $urandom, size);
		end else begin
			if (sb.list_len > 0 && roll < 70) begin
				k = $urandom_range(0, sb.list_len - 1);
				len = sb.region_len[k];
				if (roll < 40 || len <= 1) size = len;
				else size = $urandom_range(1, len - 1);
			end else if (roll < 73) begin
				size = 32'h0;
			end else if (roll < 76) begin
				size = 32'hFFFF_FFFF - $urandom_range(0, 15);
			end else begin
				size = $urandom_range(1, 4096);
			end
			r = mk_req(ACT_ALLOC, $urandom, size);
		end
	endtask

	task automatic run_random(int n);
		req_t r;
		repeat (n) begin
			pick_random_req(r);
			send_req(r);
		end
	endtask

	initial begin : request_side
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		idling_on = 1'b1;
		hold_request = 1'b0;
		cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: zero-size grant from bump, real bump grant, overflow
		send_req(mk_req(ACT_ALLOC, 32'hFFFF_FFFF, 32'h0));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'h10));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'hFFFF_FFFF));
		// zero-size free appends nothing
		send_req(mk_req(ACT_FREE, 32'hFFFF_FFFF, 32'h0));
		// split that wraps the entry start past the top of the range
		send_req(mk_req(ACT_FREE, 32'hFFFF_FFF0, 32'h100));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'h20));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'h0));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'hE0));
		// fill the list, overfill once, then take an exact fit from the middle
		for (int i = 0; i < FREE_ENTRIES - 1; i++)
			send_req(mk_req(ACT_FREE, 32'(i) << 12, 32'((i + 1) * 16)));
		send_req(mk_req(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_req(mk_req(ACT_FREE, 32'h1234_5678, 32'h40));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'h50));

		run_random(700);

		// hold the result side off while requests keep coming
		hold_request = 1'b1;
		run_random(40);

		// let every result come home before going on
		wait_for_results();
		run_random(700);

		idling_on = 1'b0;
		run_random(200);

		// bump pointer to the very top, then one past it, then a zero-size grant
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'hFFFF_FFFF - sb.bump_ptr[31:0]));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'h1));
		send_req(mk_req(ACT_ALLOC, 32'h0, 32'h0));

		wait_for_results();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d requests: %0d list grants, %0d bump grants, %0d frees",
			sb.requests, sb.status_hits[ST_LIST], sb.status_hits[ST_BUMP],
			sb.status_hits[ST_FREED]);
		$display("%0d dropped on a full list, %0d overflows, %0d mismatches",
			sb.status_hits[ST_FULL], sb.status_hits[ST_OVF], sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("first_fit_free_list_allocator regression: pass");
		end else begin
			$display("first_fit_free_list_allocator regression: fail");
		end
		$finish;
	end

endmodule
